@@ rtl/assert_macros.svh @@
// Assertion macros for the SHA-256 hasher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed");
`define CHK_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define CHK_IMPL(label, clk, rstn, ante, cons)
`define CHK_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/sha256_pkg.sv @@
// ---------------------------------------------------------------------------
// sha256_pkg
// Constants, types and round functions shared by the SHA-256 hasher.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package sha256_pkg;

  localparam int WinDepth = 16;
  localparam int WinAw    = 4;
  localparam logic [60:0] CountMax = {61{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,    // wait for a request
    ST_PUT,     // write a byte into the window (read-modify-write)
    ST_PADCHK,  // decide next pad byte
    ST_LD,      // load working variables
    ST_RD,      // issue schedule reads
    ST_RND,     // one round
    ST_FIN,     // add working vars into hash
    ST_OUT      // deliver digest words
  } state_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    case (t)
      6'd0: round_k = 32'h428a2f98;  6'd1: round_k = 32'h71374491;
      6'd2: round_k = 32'hb5c0fbcf;  6'd3: round_k = 32'he9b5dba5;
      6'd4: round_k = 32'h3956c25b;  6'd5: round_k = 32'h59f111f1;
      6'd6: round_k = 32'h923f82a4;  6'd7: round_k = 32'hab1c5ed5;
      6'd8: round_k = 32'hd807aa98;  6'd9: round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be; 6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74; 6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7; 6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1; 6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6; 6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f; 6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc; 6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152; 6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8; 6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3; 6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351; 6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85; 6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc; 6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354; 6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e; 6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1; 6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70; 6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819; 6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585; 6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116; 6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c; 6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3; 6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f; 6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee; 6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814; 6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa; 6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7; default: round_k = 32'hc67178f2;
    endcase
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    case (i)
      3'd0: init_h = 32'h6a09e667; 3'd1: init_h = 32'hbb67ae85;
      3'd2: init_h = 32'h3c6ef372; 3'd3: init_h = 32'ha54ff53a;
      3'd4: init_h = 32'h510e527f; 3'd5: init_h = 32'h9b05688c;
      3'd6: init_h = 32'h1f83d9ab; default: init_h = 32'h5be0cd19;
    endcase
  endfunction

endpackage

@@ rtl/sha256_message_hasher_top.sv @@
// ---------------------------------------------------------------------------
// sha256_message_hasher_top
// SHA-256 hasher: one byte per request; a byte request passes through accept,
// read-modify-write of the schedule memory, and the next-step decision (or
// compression, after the last byte of a block). A full 64-byte block is
// compressed by a load step, one schedule read for each of rounds 0..15,
// four schedule reads for each of rounds 16..63 (through the single read
// port), and a step to add the working variables into the hash. On end of
// message each pad byte (0x80, zero fill, length) is chosen, then written;
// then the eight digest words follow, one per accepted output request. The
// input stays stalled from the accepted request until the block is idle again.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha256_message_hasher_top
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_word_index,
  output logic [31:0] out_digest_word,
  output logic        out_last_word,
  output logic        out_length_overflow
);

  // schedule window memory
  logic [31:0] win_mem [WinDepth];
  logic [WinAw-1:0] rd_addr, wr_addr;
  logic [31:0] rd_data_r, wr_data;
  logic wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) win_mem[wr_addr] <= wr_data;
    rd_data_r <= win_mem[rd_addr];
  end

  state_t state_r, state_nxt;
  logic [60:0] cnt_r, cnt_nxt;
  logic ovf_r, ovf_nxt;
  logic [31:0] h_r [8];
  logic [5:0] pos_r, pos_nxt;     // block position of byte in flight
  logic [7:0] byte_r, byte_nxt;
  logic pad_r, pad_nxt;           // finishing the message
  logic mark_r, mark_nxt;         // 0x80 byte still to place
  logic len_r, len_nxt;           // placing the length bytes
  logic [5:0] t_r, t_nxt;
  logic [1:0] ph_r, ph_nxt;       // round read phase
  logic [31:0] a15_r, a2_r, a15_nxt, a2_nxt, w16_r, w16_nxt;
  logic [2:0] oidx_r, oidx_nxt;
  logic [63:0] bits;
  logic [255:0] hv, vars;
  logic rnd_load, rnd_step, h_add, h_init;
  logic [31:0] w_cur, s0w, s1w, wnew;

  assign bits = {cnt_r, 3'b000};
  always_comb for (int i = 0; i < 8; i++) hv[255-32*i -: 32] = h_r[i];

  // schedule expansion from read words
  assign s0w = rotr(a15_r, 7) ^ rotr(a15_r, 18) ^ (a15_r >> 3);
  assign s1w = rotr(a2_r, 17) ^ rotr(a2_r, 19) ^ (a2_r >> 10);
  assign wnew = w16_r + s0w + rd_data_r + s1w;
  assign w_cur = (t_r >= 6'd16) ? wnew : w16_r;

  sha256_round u_round (
    .clk(clk), .load(rnd_load), .load_val(hv), .step(rnd_step),
    .w(w_cur), .t(t_r), .vars(vars)
  );

  // next state and control
  always_comb begin
    logic [31:0] merged;
    logic [4:0] sh;
    state_nxt = state_r;
    cnt_nxt = cnt_r; ovf_nxt = ovf_r; pos_nxt = pos_r; byte_nxt = byte_r;
    pad_nxt = pad_r; mark_nxt = mark_r; len_nxt = len_r;
    t_nxt = t_r; ph_nxt = ph_r; oidx_nxt = oidx_r;
    a15_nxt = a15_r; a2_nxt = a2_r; w16_nxt = w16_r;
    rd_addr = pos_r[5:2]; wr_addr = pos_r[5:2]; wr_data = '0; wr_en = 1'b0;
    rnd_load = 1'b0; rnd_step = 1'b0; h_add = 1'b0; h_init = 1'b0;
    in_stall = 1'b1;
    sh = {~pos_r[1:0], 3'b000};
    merged = (pos_r[1:0] == 2'd0) ? ({24'd0, byte_r} << sh)
                                  : (rd_data_r | ({24'd0, byte_r} << sh));
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          pad_nxt = in_end_of_message;
          mark_nxt = 1'b0;
          len_nxt = 1'b0;
          if (in_byte_present && cnt_r != CountMax) begin
            pos_nxt = cnt_r[5:0]; byte_nxt = in_byte_value;
            cnt_nxt = cnt_r + 61'd1;
            rd_addr = cnt_r[5:2];
            mark_nxt = in_end_of_message;
            state_nxt = ST_PUT;
          end else begin
            if (in_byte_present) ovf_nxt = 1'b1;
            if (in_end_of_message) begin
              pos_nxt = cnt_r[5:0]; byte_nxt = 8'h80;
              rd_addr = cnt_r[5:2];
              state_nxt = ST_PUT;
            end
          end
        end
      end
      ST_PUT: begin
        wr_en = 1'b1; wr_data = merged;
        if (pos_r == 6'd63) begin
          state_nxt = ST_LD;
        end else state_nxt = ST_PADCHK;
      end
      ST_PADCHK: begin
        // choose next pad byte, deliver the digest or finish the request
        if (!pad_r) state_nxt = ST_IDLE;
        else if (len_r && pos_r == 6'd63) begin
          state_nxt = ST_OUT; oidx_nxt = '0;
        end else begin
          pos_nxt = pos_r + 6'd1;
          state_nxt = ST_PUT;
          rd_addr = pos_nxt[5:2];
          if (mark_r) begin
            byte_nxt = 8'h80; mark_nxt = 1'b0;
          end else if (len_r || pos_nxt == 6'd56) begin
            byte_nxt = bits[{~pos_nxt[2:0], 3'b000} +: 8]; len_nxt = 1'b1;
          end else byte_nxt = 8'h00;
        end
      end
      ST_LD: begin
        rnd_load = 1'b1; t_nxt = '0; ph_nxt = '0;
        rd_addr = '0; state_nxt = ST_RD;
      end
      ST_RD: begin
        // phase 0: w[t] arrives; 1: w[t+1] arrives; 2: w[t+14] arrives
        case (ph_r)
          2'd0: begin
            w16_nxt = rd_data_r;
            if (t_r < 6'd16) begin
              state_nxt = ST_RND;
            end else begin
              rd_addr = t_r[3:0] + 4'd1; ph_nxt = 2'd1;
            end
          end
          2'd1: begin
            a15_nxt = rd_data_r; rd_addr = t_r[3:0] + 4'd14; ph_nxt = 2'd2;
          end
          default: begin
            a2_nxt = rd_data_r; rd_addr = t_r[3:0] + 4'd9; state_nxt = ST_RND;
          end
        endcase
      end
      ST_RND: begin
        rnd_step = 1'b1;
        wr_addr = t_r[3:0]; wr_data = wnew; wr_en = (t_r >= 6'd16);
        t_nxt = t_r + 6'd1; ph_nxt = 2'd0;
        rd_addr = t_r[3:0] + 4'd1;
        state_nxt = (t_r == 6'd63) ? ST_FIN : ST_RD;
      end
      ST_FIN: begin
        h_add = 1'b1;
        state_nxt = ST_PADCHK;
      end
      ST_OUT: begin
        if (!out_stall) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            h_init = 1'b1; cnt_nxt = '0; ovf_nxt = 1'b0; pad_nxt = 1'b0;
            mark_nxt = 1'b0; len_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; cnt_r <= '0; ovf_r <= 1'b0; pad_r <= 1'b0;
      mark_r <= 1'b0; len_r <= 1'b0;
      t_r <= '0; ph_r <= '0; oidx_r <= '0; pos_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; ovf_r <= ovf_nxt; pad_r <= pad_nxt;
      mark_r <= mark_nxt; len_r <= len_nxt;
      t_r <= t_nxt; ph_r <= ph_nxt; oidx_r <= oidx_nxt; pos_r <= pos_nxt;
      if (h_init) for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
      else if (h_add)
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + vars[255-32*i -: 32];
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    a15_r <= a15_nxt; a2_r <= a2_nxt; w16_r <= w16_nxt;
  end

  assign out_valid = (state_r == ST_OUT);
  assign out_word_index = oidx_r;
  assign out_digest_word = h_r[oidx_r];
  assign out_last_word = (oidx_r == 3'd7);
  assign out_length_overflow = ovf_r;

  `CHK_IMPL(a_out_only_idle_no_in, clk, rst_n, out_valid, in_stall)
  `CHK_IMPL(a_last_idx, clk, rst_n, out_valid && out_last_word, out_word_index == 3'd7)
  `CHK_NEXT(a_done_idle, clk, rst_n, out_valid && !out_stall && out_last_word, !out_valid)

endmodule

@@ rtl/sha256_round.sv @@
// ---------------------------------------------------------------------------
// sha256_round
// Working-variable register file and one SHA-256 round per cycle while step is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module sha256_round
  import sha256_pkg::*;
(
  input  logic            clk,
  input  logic            load,
  input  logic [255:0]    load_val,
  input  logic            step,
  input  logic [31:0]     w,
  input  logic [5:0]      t,
  output logic [255:0]    vars
);

  logic [31:0] v_r [8];
  logic [31:0] s1, ch, t1, s0, mj, t2;

  // compute round terms
  always_comb begin
    s1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + s1 + ch + round_k(t) + w;
    s0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2 = s0 + mj;
  end

  // load or advance variables
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 8; i++) v_r[i] <= load_val[255-32*i -: 32];
    end else if (step) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) vars[255-32*i -: 32] = v_r[i];
  end

endmodule

@@ tb/sha256_message_hasher_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 digest checker
// Watches the request and digest channels, hashes every accepted message
// byte on its own and compares each digest word with the oldest prediction.
// ---------------------------------------------------------------------------
module sha256_message_hasher_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_word_index,
  input  logic [31:0] out_digest_word,
  input  logic        out_last_word,
  input  logic        out_length_overflow,
  output int          mismatch_count,
  output int          digest_words_pending
);

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] word;
    logic        last;
    logic        ovf;
  } digest_word_t;

  localparam logic [60:0] LenLimit = {61{1'b1}};

  logic [31:0] chain_h [8];
  logic [7:0]  block_bytes [64];
  logic [60:0] msg_len;
  logic        len_saturated;
  digest_word_t digest_q [$];

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] init_chain(input int i);
    logic [31:0] iv [8];
    iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
           32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return iv[i];
  endfunction

  // Compress the 64 buffered bytes into the chaining value
  task automatic compress_block();
    logic [31:0] k [64];
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
      end else begin
        w[t] = w[t-16] + w[t-7]
             + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3))
             + (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10));
      end
    end
    for (int i = 0; i < 8; i++) v[i] = chain_h[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k[t] + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
  endtask

  task automatic place_byte(input logic [5:0] pos, input logic [7:0] b);
    block_bytes[pos] = b;
    if (pos == 6'd63) compress_block();
  endtask

  // Absorb one request; on end of message pad and queue the digest
  task automatic hash_request(input logic [7:0] b, input logic present, input logic eom);
    logic [5:0]  pos;
    logic [63:0] bit_len;
    digest_word_t dw;
    if (present) begin
      if (msg_len == LenLimit) begin
        len_saturated = 1'b1;
      end else begin
        place_byte(msg_len[5:0], b);
        msg_len = msg_len + 61'd1;
      end
    end
    if (eom) begin
      pos = msg_len[5:0];
      place_byte(pos, 8'h80);
      pos = pos + 6'd1;
      while (pos != 6'd56) begin
        place_byte(pos, 8'h00);
        pos = pos + 6'd1;
      end
      bit_len = {msg_len, 3'b000};
      for (int i = 0; i < 8; i++) place_byte(6'(56 + i), bit_len[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        dw.index = 3'(i);
        dw.word  = chain_h[i];
        dw.last  = (i == 7);
        dw.ovf   = len_saturated;
        digest_q.push_back(dw);
      end
      for (int i = 0; i < 8; i++) chain_h[i] = init_chain(i);
      msg_len = '0;
      len_saturated = 1'b0;
    end
  endtask

  initial begin
    mismatch_count = 0;
    digest_words_pending = 0;
    for (int i = 0; i < 8; i++) chain_h[i] = init_chain(i);
    msg_len = '0;
    len_saturated = 1'b0;
  end

  // Predict on accepted requests, compare on accepted digest words
  always @(posedge clk) begin
    digest_word_t exp_w;
    if (rst_n) begin
      if (in_valid && !in_stall) hash_request(in_byte_value, in_byte_present, in_end_of_message);
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected digest word: index %0d word %h", out_word_index,
                     out_digest_word);
        end else begin
          exp_w = digest_q.pop_front();
          if (out_word_index !== exp_w.index || out_digest_word !== exp_w.word ||
              out_last_word !== exp_w.last || out_length_overflow !== exp_w.ovf) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"digest mismatch: exp idx %0d word %h last %b ovf %b, ",
                        "got idx %0d word %h last %b ovf %b"},
                       exp_w.index, exp_w.word, exp_w.last, exp_w.ovf, out_word_index,
                       out_digest_word, out_last_word, out_length_overflow);
          end
        end
      end
    end
    digest_words_pending = digest_q.size();
  end

endmodule

@@ tb/sha256_message_hasher_top_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 hasher testbench
// Feeds directed and random messages with random idle bursts on both
// channels; the checker predicts every digest word and counts mismatches.
// ---------------------------------------------------------------------------
module sha256_message_hasher_top_tb;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte_value;
  logic        in_byte_present;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_word_index;
  logic [31:0] out_digest_word;
  logic        out_last_word;
  logic        out_length_overflow;
  int          mismatch_count;
  int          digest_words_pending;
  logic        steady_phase;
  int          out_idle_left;
  int          byte_requests;

  sha256_message_hasher_top dut (.*);

  sha256_message_hasher_checker checker_i (.*);

  always #1 clk = ~clk;

  // Stall the digest channel in random bursts
  always @(posedge clk) begin
    if (steady_phase) begin
      out_stall <= 1'b0;
    end else if (out_idle_left > 0) begin
      out_idle_left <= out_idle_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_idle_left <= $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Drive one request and hold it until accepted, then maybe idle
  task automatic send_request(input logic [7:0] b, input logic present, input logic eom);
    int gap;
    in_valid          <= 1'b1;
    in_byte_value     <= b;
    in_byte_present   <= present;
    in_end_of_message <= eom;
    do @(posedge clk); while (in_stall);
    if (present) byte_requests++;
    if (!steady_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      send_request(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(0, 1));
    end
    if (len == 0 || !in_end_of_message) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int len;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte_value = '0;
    in_byte_present = 1'b0;
    in_end_of_message = 1'b0;
    out_stall = 1'b0;
    out_idle_left = 0;
    steady_phase = 1'b0;
    byte_requests = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, "abc", byte with end, noise, byte extremes
    send_request(8'h00, 1'b0, 1'b1);
    send_request("a", 1'b1, 1'b0);
    send_request("b", 1'b1, 1'b0);
    send_request("c", 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'h5a, 1'b0, 1'b0);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'h3c, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);

    // Random messages, with padding boundaries mixed in
    byte_requests = 0;
    while (byte_requests < 300) begin
      if (byte_requests > 240) steady_phase = 1'b1;
      case ($urandom_range(0, 7))
        0: len = 55;
        1: len = 56 + $urandom_range(0, 1);
        2: len = 63 + $urandom_range(0, 2);
        3: len = $urandom_range(100, 130);
        default: len = $urandom_range(0, 24);
      endcase
      if (len > 300 - byte_requests) len = 300 - byte_requests;
      send_message(len);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (digest_words_pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/sha256_pkg.sv
rtl/sha256_round.sv
rtl/sha256_message_hasher_top.sv
tb/sha256_message_hasher_checker.sv
tb/sha256_message_hasher_top_tb.sv
